// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== design/rtd_pkg.sv =====
package rtd_pkg;

    // Widths of the ports and of the internal arithmetic.
    localparam int RES_W    = 20;
    localparam int TEMP_W   = 17;
    localparam int IDX_W    = 6;
    localparam int SPAN_W   = 15;
    localparam int DT_W     = 13;
    localparam int PROD_W   = SPAN_W + DT_W;
    localparam int QUOT_W   = DT_W;
    localparam int CNT_W    = 4;

    // Number of breakpoints held in the table.
    localparam int STORED_POINTS = 35;

    // One quotient bit is produced per division step.
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUOT_W);

    // Breakpoint resistances in centiohm, strictly increasing.
    localparam logic [RES_W-1:0] OHM_TABLE [STORED_POINTS] = '{
        20'd72330,  20'd76330,  20'd80310,  20'd84270,  20'd88220,
        20'd92160,  20'd96090,  20'd100000, 20'd103900, 20'd107790,
        20'd111670, 20'd115540, 20'd119400, 20'd123240, 20'd127080,
        20'd130900, 20'd134710, 20'd138510, 20'd142290, 20'd146060,
        20'd148330, 20'd149830, 20'd153580, 20'd157330, 20'd161050,
        20'd164770, 20'd168480, 20'd172170, 20'd175860, 20'd194100,
        20'd212050, 20'd229720, 20'd247090, 20'd264180, 20'd280980
    };

    // Breakpoint temperatures in centidegree.
    localparam logic signed [TEMP_W-1:0] TEMP_TABLE [STORED_POINTS] = '{
        -17'sd7000, -17'sd6000, -17'sd5000, -17'sd4000, -17'sd3000,
        -17'sd2000, -17'sd1000,  17'sd0,     17'sd1000,  17'sd2000,
         17'sd3000,  17'sd4000,  17'sd5000,  17'sd6000,  17'sd7000,
         17'sd8000,  17'sd9000,  17'sd10000, 17'sd11000, 17'sd12000,
         17'sd12600, 17'sd13000, 17'sd14000, 17'sd15000, 17'sd16000,
         17'sd17000, 17'sd18000, 17'sd19000, 17'sd20000, 17'sd25000,
         17'sd30000, 17'sd35000, 17'sd40000, 17'sd45000, 17'sd50000
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search_step;
        logic mul;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clamp;
        logic search_done;
    } dp_status_t;

endpackage

// ===== design/rtd_ctrl.sv =====
module rtd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rtd_pkg::dp_status_t status,
    output rtd_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [rtd_pkg::CNT_W-1:0]  cnt_reg;
    logic [rtd_pkg::CNT_W-1:0]  cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    // Sequencing of one request: search, multiply, divide, hand over; a clamp goes from search to hand-over.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.clamp)
                begin
                    state_next = S_DONE;
                end
                else if (status.search_done)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == rtd_pkg::DIV_STEPS - 1'b1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is full from the hand-over until the result is taken.
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/rtd_dp.sv =====
module rtd_dp #(
    parameter int TABLE_POINTS = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtd_pkg::ctrl_cmd_t                 cmd,
    output rtd_pkg::dp_status_t                status,
    input  logic [rtd_pkg::RES_W-1:0]          resistance_centiohm,
    output logic signed [rtd_pkg::TEMP_W-1:0]  temperature_centidegree
);

    // Points in use: at least two, at most what the table holds.
    localparam int USED_POINTS = (TABLE_POINTS > rtd_pkg::STORED_POINTS) ?
                                 rtd_pkg::STORED_POINTS :
                                 ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam logic [rtd_pkg::IDX_W-1:0] LAST_IDX = rtd_pkg::IDX_W'(USED_POINTS - 1);

    logic [rtd_pkg::RES_W-1:0]          r_reg;
    logic [rtd_pkg::IDX_W-1:0]          lo_reg;
    logic [rtd_pkg::IDX_W-1:0]          hi_reg;
    logic                               clamp_reg;
    logic [rtd_pkg::PROD_W-1:0]         rem_reg;
    logic [rtd_pkg::PROD_W-1:0]         dsh_reg;
    logic [rtd_pkg::QUOT_W-1:0]         q_reg;
    logic signed [rtd_pkg::TEMP_W-1:0]  temp_reg;

    logic [rtd_pkg::IDX_W:0]            mid_sum;
    logic [rtd_pkg::IDX_W-1:0]          mid;
    logic [rtd_pkg::RES_W-1:0]          r_off;
    logic [rtd_pkg::RES_W-1:0]          span_full;
    logic signed [rtd_pkg::TEMP_W-1:0]  dt_full;
    logic [rtd_pkg::PROD_W-1:0]         product;
    logic                               div_ge;
    logic                               below;
    logic                               above;

    // Bisection: the segment index keeps ohm[lo] < r <= ohm[hi].
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[rtd_pkg::IDX_W:1];

    // Offset into the segment, its span and its temperature rise.
    assign r_off     = r_reg - rtd_pkg::OHM_TABLE[lo_reg];
    assign span_full = rtd_pkg::OHM_TABLE[hi_reg] - rtd_pkg::OHM_TABLE[lo_reg];
    assign dt_full   = rtd_pkg::TEMP_TABLE[hi_reg] - rtd_pkg::TEMP_TABLE[lo_reg];
    assign product   = rtd_pkg::PROD_W'(r_off[rtd_pkg::SPAN_W-1:0]) *
                       rtd_pkg::PROD_W'(dt_full[rtd_pkg::DT_W-1:0]);

    // Restoring division, one quotient bit per step.
    assign div_ge = (rem_reg >= dsh_reg);

    // Range checks against the end points on the incoming request.
    assign below = (resistance_centiohm <= rtd_pkg::OHM_TABLE[0]);
    assign above = (resistance_centiohm >= rtd_pkg::OHM_TABLE[LAST_IDX]);

    assign status.clamp       = clamp_reg;
    assign status.search_done = ((hi_reg - lo_reg) == rtd_pkg::IDX_W'(1));

    assign temperature_centidegree = temp_reg;

    // Control flag of the clamp case.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            clamp_reg <= below || above;
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg  <= resistance_centiohm;
            q_reg  <= '0;
            hi_reg <= LAST_IDX;
            lo_reg <= above ? LAST_IDX : '0;
        end
        if (cmd.search_step)
        begin
            if (rtd_pkg::OHM_TABLE[mid] < r_reg)
            begin
                lo_reg <= mid;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.mul)
        begin
            rem_reg <= product;
            dsh_reg <= rtd_pkg::PROD_W'(span_full[rtd_pkg::SPAN_W-1:0]) << (rtd_pkg::QUOT_W - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[rtd_pkg::QUOT_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.finish)
        begin
            temp_reg <= rtd_pkg::TEMP_TABLE[lo_reg] +
                        signed'({{(rtd_pkg::TEMP_W - rtd_pkg::QUOT_W){1'b0}}, q_reg});
        end
    end

endmodule

// ===== design/rtd_resistance_to_temperature_top.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_ready   resistance_centiohm (20 bit unsigned)
// output    out        out_valid/out_ready temperature_centidegree (17 bit signed)
//
// One request is worked at a time; in_ready is high only while the controller idles.
// From accept to accept a request passes the idle state that accepts it, up to six
// bisection steps and the search state that sees the segment, one multiply, thirteen
// division steps and one hand-over. Clamped requests go from search straight to hand-over.
// A result waiting for out_ready holds only the hand-over; the next request is still taken.
// Reset clears the controller and the output valid flag; no clearing pass is needed.
`include "assert_macros.svh"

module rtd_resistance_to_temperature_top #(
    parameter int TABLE_POINTS = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rtd_pkg::RES_W-1:0]          resistance_centiohm,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rtd_pkg::TEMP_W-1:0]  temperature_centidegree
);

    rtd_pkg::ctrl_cmd_t  cmd;
    rtd_pkg::dp_status_t status;
    logic                temp_in_range;

    // Controller state machine.
    rtd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Search, multiply and divide datapath.
    rtd_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .status                  (status),
        .resistance_centiohm     (resistance_centiohm),
        .temperature_centidegree (temperature_centidegree)
    );

    // The shown temperature lies between the two end points of the table.
    assign temp_in_range = (temperature_centidegree >= -17'sd7000) &&
                           (temperature_centidegree <= 17'sd50000);

    // An accepted request keeps the input closed on the next cycle.
    `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "input open after accept")

    // A hand-over always leaves a valid result in the output register.
    `ASSERT_CLK(a_finish_fills_out, cmd.finish |=> out_valid, "result lost at hand-over")

    // A result shown is within the table's temperature range.
    `ASSERT_ALWAYS(a_out_range, !out_valid || temp_in_range, "temperature out of range")

endmodule
